/* hw/rtl/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions of the sorted list table
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int DefCapacity = 16;
  localparam int DataW       = 32;
  localparam int CountOutW   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_FIN  = 2'd2,
    S_RESP = 2'd3
  } state_e;

endpackage

/* hw/rtl/slt_ram.sv */
// ----------------------------------------------------------------------------
// slt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/sorted_list_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_list_table_core: bounded sorted store of signed 32-bit values
// Insert, search, delete and pop on an ascending table held in a RAM,
// walked one entry per cycle by a small sequencer around one less-than and one equality compare.
// ----------------------------------------------------------------------------
//  Channel   Signals                                              Direction
//  request   in_valid_i, in_stall_o, operation_i, value_i          in
//  result    out_valid_o, out_stall_i, status_o, found_o,          out
//            popped_value_o, entry_count_o
//
// A walked request passes a registered RAM read, the walk over the entries in S_RUN,
// the result state S_RESP and then S_IDLE before the next is accepted. An insert
// adds S_FIN for its final write, and a search stops at the first entry not below
// the value. A full insert or a search, delete or pop on an empty table goes straight
// to S_RESP, and an insert into an empty table through S_FIN. in_stall_o stays high from
// acceptance until the result is taken; reset empties the table without a clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_table_core #(
  parameter int Capacity = slt_pkg::DefCapacity
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  slt_pkg::op_e                   operation_i,
  input  logic signed [slt_pkg::DataW-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output slt_pkg::status_e               status_o,
  output logic                           found_o,
  output logic signed [slt_pkg::DataW-1:0] popped_value_o,
  output logic [slt_pkg::CountOutW-1:0]  entry_count_o
);
  import slt_pkg::*;

  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW = $clog2(Capacity + 1);

  state_e                   state_q, state_d;
  op_e                      op_q, op_d;
  logic signed [DataW-1:0]  val_q, val_d;
  logic [IdxW-1:0]          rptr_q, rptr_d;
  logic [IdxW-1:0]          daddr_q;
  logic                     dv_q;
  logic                     shift_q, shift_d;
  logic [IdxW-1:0]          ins_pos_q, ins_pos_d;
  logic [CntW-1:0]          count_q, count_d;
  status_e                  status_q, status_d;
  logic                     found_q, found_d;
  logic signed [DataW-1:0]  popped_q, popped_d;

  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [DataW-1:0]         ram_wdata;
  logic signed [DataW-1:0]  rdata;

  logic                     accept;
  logic [CntW-1:0]          cnt_m1;
  logic                     is_full;
  logic                     is_empty;
  logic                     is_last;
  logic                     cmp_eq;
  logic                     cmp_lt;
  logic                     match;
  logic [CntW+CountOutW-1:0] cnt_ext;

  slt_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rptr_q),
    .rdata_o(rdata)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign cnt_m1   = count_q - 1'b1;
  assign is_full  = (count_q == CntW'(Capacity));
  assign is_empty = (count_q == '0);
  assign is_last  = (CntW'(daddr_q) == cnt_m1);
  assign cmp_eq   = (rdata == val_q);
  assign cmp_lt   = (rdata < val_q);
  assign match    = (op_q == OP_POP) || cmp_eq;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_INSERT: state_d = is_full ? S_RESP : (is_empty ? S_FIN : S_RUN);
            default:   state_d = is_empty ? S_RESP : S_RUN;
          endcase
        end
      end
      S_RUN: begin
        if (dv_q) begin
          case (op_q)
            OP_INSERT: begin
              if (cmp_lt || daddr_q == '0) begin
                state_d = S_FIN;
              end
            end
            OP_SEARCH: begin
              if (cmp_eq || !cmp_lt || is_last) begin
                state_d = S_RESP;
              end
            end
            default: begin
              if (is_last) begin
                state_d = S_RESP;
              end
            end
          endcase
        end
      end
      S_FIN:   state_d = S_RESP;
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    op_d      = op_q;
    val_d     = val_q;
    rptr_d    = rptr_q;
    shift_d   = shift_q;
    ins_pos_d = ins_pos_q;
    count_d   = count_q;
    status_d  = status_q;
    found_d   = found_q;
    popped_d  = popped_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = operation_i;
          val_d     = value_i;
          shift_d   = 1'b0;
          found_d   = 1'b0;
          popped_d  = '0;
          ins_pos_d = '0;
          status_d  = ST_OK;
          rptr_d    = (operation_i == OP_INSERT) ? cnt_m1[IdxW-1:0] : '0;
          case (operation_i)
            OP_INSERT: if (is_full) status_d = ST_FULL;
            OP_SEARCH: if (is_empty) status_d = ST_NOT_FOUND;
            default:   if (is_empty) status_d = ST_EMPTY;
          endcase
        end
      end
      S_RUN: begin
        rptr_d = (op_q == OP_INSERT) ? rptr_q - 1'b1 : rptr_q + 1'b1;
        if (dv_q) begin
          case (op_q)
            OP_INSERT: begin
              if (cmp_lt) begin
                ins_pos_d = daddr_q + 1'b1;
              end else begin
                ins_pos_d = '0;
              end
            end
            OP_SEARCH: begin
              if (cmp_eq) begin
                found_d = 1'b1;
              end else if (!cmp_lt || is_last) begin
                status_d = ST_NOT_FOUND;
              end
            end
            default: begin
              if (!shift_q && match) begin
                shift_d = 1'b1;
                if (op_q == OP_POP) begin
                  popped_d = rdata;
                end
              end
              if (is_last) begin
                if (shift_q || match) begin
                  count_d = count_q - 1'b1;
                end else begin
                  status_d = ST_NOT_FOUND;
                end
              end
            end
          endcase
        end
      end
      S_FIN: count_d = count_q + 1'b1;
      default: ;
    endcase
  end

  // Outputs and RAM write port.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = ins_pos_q;
    ram_wdata   = val_q;
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_RESP);
    case (state_q)
      S_RUN: begin
        if (dv_q) begin
          case (op_q)
            OP_INSERT: begin
              ram_we    = !cmp_lt;
              ram_waddr = daddr_q + 1'b1;
              ram_wdata = rdata;
            end
            OP_SEARCH: ram_we = 1'b0;
            default: begin
              ram_we    = shift_q;
              ram_waddr = daddr_q - 1'b1;
              ram_wdata = rdata;
            end
          endcase
        end
      end
      S_FIN:   ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  assign status_o       = status_q;
  assign found_o        = found_q;
  assign popped_value_o = popped_q;
  assign cnt_ext        = (CntW + CountOutW)'(count_q);
  assign entry_count_o  = cnt_ext[CountOutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      dv_q    <= 1'b0;
      shift_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      dv_q    <= (state_q == S_RUN);
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    rptr_q    <= rptr_d;
    daddr_q   <= rptr_q;
    ins_pos_q <= ins_pos_d;
    status_q  <= status_d;
    found_q   <= found_d;
    popped_q  <= popped_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("Entry count exceeds the capacity.");

  a_one_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("A request was taken while a result was pending.");

  a_write_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_RUN || state_q == S_FIN))
    else $error("Table written outside an operation.");

  a_count_at_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (state_q == S_RESP))
    else $error("Entry count changed without a result.");
`endif

endmodule
